[hw/rtl/timestamp_arith_unit_top_defines.svh]
// Assertion macros shared by the timestamp arithmetic RTL
`ifndef TIMESTAMP_ARITH_UNIT_TOP_DEFINES_SVH
`define TIMESTAMP_ARITH_UNIT_TOP_DEFINES_SVH
`ifndef SYNTH
`define TSAU_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("tsau: same-cycle check failed");
`define TSAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("tsau: next-cycle check failed");
`else
`define TSAU_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define TSAU_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

[hw/rtl/tsau_pkg.sv]
// Types and constants for the timestamp arithmetic unit
package tsau_pkg;

    localparam int FRAC_W   = 12;
    localparam int COARSE_W = 27;
    localparam int SEC_W    = 64;
    localparam int HALF_W   = SEC_W / 2;

    localparam int FRAC_BINS        = 4096;       // power of two: division is a shift
    localparam int TICKS_PER_SECOND = 125000000;
    localparam int FRAC_SHIFT       = $clog2(FRAC_BINS);

    localparam logic [63:0] PS_PER_SECOND = 64'd1000000000000;
    localparam logic [63:0] NS_PER_SECOND = 64'd1000000000;
    localparam logic [63:0] PS_PER_TICK   = PS_PER_SECOND / 64'(TICKS_PER_SECOND);
    localparam logic [63:0] NS_PER_TICK   = NS_PER_SECOND / 64'(TICKS_PER_SECOND);
    localparam int          PS_PER_NS     = 1000;

    localparam int TICK_K_W = $clog2(PS_PER_TICK + 64'd1);
    localparam int CP_W     = COARSE_W + TICK_K_W;  // coarse * per-tick product
    localparam int FP_W     = TICK_K_W;             // picoseconds inside one tick
    localparam int Q_W      = $clog2(PS_PER_TICK / 64'(PS_PER_NS) + 64'd1);

    // fp / 1000 as (fp * K) >> S, exact for fp below 8000
    localparam int NS_DIV_S   = 23;
    localparam int NS_DIV_K   = ((1 << NS_DIV_S) + PS_PER_NS - 1) / PS_PER_NS;
    localparam int NS_DIV_K_W = $clog2(NS_DIV_K + 1);

    // seconds multiplier split into a low 32-bit and a high 8-bit part
    localparam int               SEC_KH_W  = 8;
    localparam logic [31:0]      SEC_KL_PS = PS_PER_SECOND[31:0];
    localparam logic [7:0]       SEC_KH_PS = PS_PER_SECOND[39:32];
    localparam logic [31:0]      SEC_KL_NS = NS_PER_SECOND[31:0];

    localparam int TICK_W = $clog2(TICKS_PER_SECOND + 1);
    localparam int D_W    = ((TICK_W > COARSE_W) ? TICK_W : COARSE_W) + 2;
    localparam logic [D_W-1:0]    TICKS_D     = D_W'(TICKS_PER_SECOND);
    localparam logic [FRAC_W:0]   FRAC_BINS_F = (FRAC_W + 1)'(FRAC_BINS);

    localparam int NUM_STAGES = 4;

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_PS  = 2'd2,
        ACT_NS  = 2'd3
    } t_action;

    typedef struct packed {
        logic                  run;  // out of reset
        logic [NUM_STAGES-1:0] adv;  // stage register loads
        logic [NUM_STAGES-1:0] vld;  // stage register holds a transaction
    } t_pipe_ctl;

endpackage

[hw/rtl/tsau_tstamp.sv]
// Add and subtract path: frac carry, coarse wrap, seconds carry over four stages
`include "timestamp_arith_unit_top_defines.svh"
module tsau_tstamp (
    input  logic                           i_clk,
    input  tsau_pkg::t_pipe_ctl            i_ctl,
    input  logic [1:0]                     i_action,
    input  logic [tsau_pkg::SEC_W-1:0]     i_a_seconds,
    input  logic [tsau_pkg::COARSE_W-1:0]  i_a_coarse,
    input  logic [tsau_pkg::FRAC_W-1:0]    i_a_frac,
    input  logic [tsau_pkg::SEC_W-1:0]     i_b_seconds,
    input  logic [tsau_pkg::COARSE_W-1:0]  i_b_coarse,
    input  logic [tsau_pkg::FRAC_W-1:0]    i_b_frac,
    output logic [tsau_pkg::SEC_W-1:0]     o_res_seconds,
    output logic [tsau_pkg::COARSE_W-1:0]  o_res_coarse,
    output logic [tsau_pkg::FRAC_W-1:0]    o_res_frac
);

    tsau_pkg::t_action                 w_act;
    logic [tsau_pkg::FRAC_W:0]         w_fsum;
    logic                              n1_flag;
    logic [tsau_pkg::FRAC_W-1:0]       n1_f;
    logic [tsau_pkg::D_W-1:0]          n1_d;
    logic [tsau_pkg::SEC_W-1:0]        n1_s;

    tsau_pkg::t_action                 r1_act;
    logic                              r1_flag;
    logic [tsau_pkg::FRAC_W-1:0]       r1_f;
    logic [tsau_pkg::D_W-1:0]          r1_d;
    logic [tsau_pkg::SEC_W-1:0]        r1_s;

    logic [tsau_pkg::D_W-1:0]          n2_d;
    tsau_pkg::t_action                 r2_act;
    logic [tsau_pkg::FRAC_W-1:0]       r2_f;
    logic [tsau_pkg::D_W-1:0]          r2_d;
    logic [tsau_pkg::SEC_W-1:0]        r2_s;

    logic                              n3_wrap;
    logic [tsau_pkg::D_W-1:0]          n3_d;
    tsau_pkg::t_action                 r3_act;
    logic                              r3_wrap;
    logic [tsau_pkg::FRAC_W-1:0]       r3_f;
    logic [tsau_pkg::COARSE_W-1:0]     r3_c;
    logic [tsau_pkg::SEC_W-1:0]        r3_s;

    logic [tsau_pkg::SEC_W-1:0]        n4_s;
    logic [tsau_pkg::SEC_W-1:0]        r4_s;
    logic [tsau_pkg::COARSE_W-1:0]     r4_c;
    logic [tsau_pkg::FRAC_W-1:0]       r4_f;

    // stage 1: frac carry/borrow, raw coarse and seconds sums
    always_comb begin
        w_act   = tsau_pkg::t_action'(i_action);
        w_fsum  = '0;
        n1_flag = 1'b0;
        n1_f    = i_a_frac;
        n1_d    = tsau_pkg::D_W'(i_a_coarse);
        n1_s    = i_a_seconds;
        case (w_act)
            tsau_pkg::ACT_ADD: begin
                w_fsum  = {1'b0, i_a_frac} + {1'b0, i_b_frac};
                n1_flag = (w_fsum >= tsau_pkg::FRAC_BINS_F);
                n1_f    = n1_flag ? tsau_pkg::FRAC_W'(w_fsum - tsau_pkg::FRAC_BINS_F)
                                  : w_fsum[tsau_pkg::FRAC_W-1:0];
                n1_d    = tsau_pkg::D_W'(i_a_coarse) + tsau_pkg::D_W'(i_b_coarse);
                n1_s    = i_a_seconds + i_b_seconds;
            end
            tsau_pkg::ACT_SUB: begin
                n1_flag = (i_a_frac < i_b_frac);
                w_fsum  = {1'b0, i_a_frac} - {1'b0, i_b_frac}
                        + (n1_flag ? tsau_pkg::FRAC_BINS_F : '0);
                n1_f    = w_fsum[tsau_pkg::FRAC_W-1:0];
                n1_d    = tsau_pkg::D_W'(i_a_coarse) - tsau_pkg::D_W'(i_b_coarse);
                n1_s    = i_a_seconds - i_b_seconds;
            end
            default: begin
                // conversions pass operand a through
            end
        endcase
    end

    // stage 2: fold the frac carry into coarse
    always_comb begin
        case (r1_act)
            tsau_pkg::ACT_ADD: n2_d = r1_d + tsau_pkg::D_W'(r1_flag);
            tsau_pkg::ACT_SUB: n2_d = r1_d - tsau_pkg::D_W'(r1_flag);
            default:           n2_d = r1_d;
        endcase
    end

    // stage 3: wrap coarse at one second
    always_comb begin
        n3_wrap = 1'b0;
        n3_d    = r2_d;
        case (r2_act)
            tsau_pkg::ACT_ADD: begin
                n3_wrap = (r2_d >= tsau_pkg::TICKS_D);
                if (n3_wrap) begin
                    n3_d = r2_d - tsau_pkg::TICKS_D;
                end
            end
            tsau_pkg::ACT_SUB: begin
                n3_wrap = r2_d[tsau_pkg::D_W-1];  // negative: borrow a second
                if (n3_wrap) begin
                    n3_d = r2_d + tsau_pkg::TICKS_D;
                end
            end
            default: begin
                n3_wrap = 1'b0;
            end
        endcase
    end

    // stage 4: seconds carry/borrow
    always_comb begin
        if (r3_act == tsau_pkg::ACT_SUB) begin
            n4_s = r3_s - tsau_pkg::SEC_W'(r3_wrap);
        end else begin
            n4_s = r3_s + tsau_pkg::SEC_W'(r3_wrap);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_act  <= w_act;
            r1_flag <= n1_flag;
            r1_f    <= n1_f;
            r1_d    <= n1_d;
            r1_s    <= n1_s;
        end
        if (i_ctl.adv[1]) begin
            r2_act <= r1_act;
            r2_f   <= r1_f;
            r2_d   <= n2_d;
            r2_s   <= r1_s;
        end
        if (i_ctl.adv[2]) begin
            r3_act  <= r2_act;
            r3_wrap <= n3_wrap;
            r3_f    <= r2_f;
            r3_c    <= n3_d[tsau_pkg::COARSE_W-1:0];
            r3_s    <= r2_s;
        end
        if (i_ctl.adv[3]) begin
            r4_s <= n4_s;
            r4_c <= r3_c;
            r4_f <= r3_f;
        end
    end

    assign o_res_seconds = r4_s;
    assign o_res_coarse  = r4_c;
    assign o_res_frac    = r4_f;

    // a second may only be carried or borrowed by add and subtract
    `TSAU_ASSERT_IMP(a_wrap_only_arith, i_clk, i_ctl.run, i_ctl.vld[2] && r3_wrap, r3_act == tsau_pkg::ACT_ADD || r3_act == tsau_pkg::ACT_SUB)

endmodule

[hw/rtl/tsau_scalar.sv]
// Conversion path: picoseconds or nanoseconds from operand a over four stages
`include "timestamp_arith_unit_top_defines.svh"
module tsau_scalar (
    input  logic                           i_clk,
    input  tsau_pkg::t_pipe_ctl            i_ctl,
    input  logic [1:0]                     i_action,
    input  logic [tsau_pkg::SEC_W-1:0]     i_a_seconds,
    input  logic [tsau_pkg::COARSE_W-1:0]  i_a_coarse,
    input  logic [tsau_pkg::FRAC_W-1:0]    i_a_frac,
    output logic [tsau_pkg::SEC_W-1:0]     o_res_scalar
);

    tsau_pkg::t_action                               w_act;
    logic                                            w_ps;
    logic [tsau_pkg::HALF_W-1:0]                     w_kl;
    logic [tsau_pkg::SEC_KH_W-1:0]                   w_kh;
    logic [tsau_pkg::TICK_K_W-1:0]                   w_kt;
    logic [tsau_pkg::FRAC_W+tsau_pkg::TICK_K_W-1:0]  w_fprod;

    logic [tsau_pkg::SEC_W-1:0]                      n1_ll;
    logic [tsau_pkg::HALF_W-1:0]                     n1_lh;
    logic [tsau_pkg::HALF_W-1:0]                     n1_hl;
    logic [tsau_pkg::CP_W-1:0]                       n1_cp;
    logic [tsau_pkg::FP_W-1:0]                       n1_fp;

    logic                                            r1_conv;
    logic                                            r1_ps;
    logic [tsau_pkg::SEC_W-1:0]                      r1_ll;
    logic [tsau_pkg::HALF_W-1:0]                     r1_lh;
    logic [tsau_pkg::HALF_W-1:0]                     r1_hl;
    logic [tsau_pkg::CP_W-1:0]                       r1_cp;
    logic [tsau_pkg::FP_W-1:0]                       r1_fp;

    logic [tsau_pkg::FP_W+tsau_pkg::NS_DIV_K_W-1:0]  w_qprod;
    logic [tsau_pkg::Q_W-1:0]                        w_q;
    logic                                            r2_conv;
    logic [tsau_pkg::SEC_W-1:0]                      r2_ll;
    logic [tsau_pkg::HALF_W-1:0]                     r2_cross;
    logic [tsau_pkg::CP_W-1:0]                       r2_cp;
    logic [tsau_pkg::FP_W-1:0]                       r2_fr;

    logic                                            r3_conv;
    logic [tsau_pkg::SEC_W-1:0]                      r3_t;
    logic [tsau_pkg::CP_W:0]                         r3_u;

    logic [tsau_pkg::SEC_W-1:0]                      r4_scalar;

    // stage 1: partial products; seconds * K mod 2^64 needs only the low
    // half of the two cross terms
    always_comb begin
        w_act   = tsau_pkg::t_action'(i_action);
        w_ps    = (w_act == tsau_pkg::ACT_PS);
        w_kl    = w_ps ? tsau_pkg::SEC_KL_PS : tsau_pkg::SEC_KL_NS;
        w_kh    = w_ps ? tsau_pkg::SEC_KH_PS : '0;
        w_kt    = w_ps ? tsau_pkg::TICK_K_W'(tsau_pkg::PS_PER_TICK)
                       : tsau_pkg::TICK_K_W'(tsau_pkg::NS_PER_TICK);
        n1_ll   = tsau_pkg::SEC_W'(i_a_seconds[tsau_pkg::HALF_W-1:0])
                * tsau_pkg::SEC_W'(w_kl);
        n1_lh   = tsau_pkg::HALF_W'(i_a_seconds[tsau_pkg::HALF_W-1:0]
                * tsau_pkg::HALF_W'(w_kh));
        n1_hl   = tsau_pkg::HALF_W'(i_a_seconds[tsau_pkg::SEC_W-1:tsau_pkg::HALF_W] * w_kl);
        n1_cp   = tsau_pkg::CP_W'(i_a_coarse) * tsau_pkg::CP_W'(w_kt);
        w_fprod = (tsau_pkg::FRAC_W + tsau_pkg::TICK_K_W)'(i_a_frac)
                * (tsau_pkg::FRAC_W + tsau_pkg::TICK_K_W)'(tsau_pkg::PS_PER_TICK);
        n1_fp   = tsau_pkg::FP_W'(w_fprod >> tsau_pkg::FRAC_SHIFT);
    end

    // stage 2: ns fraction by reciprocal
    always_comb begin
        w_qprod = (tsau_pkg::FP_W + tsau_pkg::NS_DIV_K_W)'(r1_fp)
                * (tsau_pkg::FP_W + tsau_pkg::NS_DIV_K_W)'(tsau_pkg::NS_DIV_K);
        w_q     = w_qprod[tsau_pkg::NS_DIV_S +: tsau_pkg::Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r1_conv <= (w_act == tsau_pkg::ACT_PS) || (w_act == tsau_pkg::ACT_NS);
            r1_ps   <= w_ps;
            r1_ll   <= n1_ll;
            r1_lh   <= n1_lh;
            r1_hl   <= n1_hl;
            r1_cp   <= n1_cp;
            r1_fp   <= n1_fp;
        end
        if (i_ctl.adv[1]) begin
            r2_conv  <= r1_conv;
            r2_ll    <= r1_ll;
            r2_cross <= r1_lh + r1_hl;
            r2_cp    <= r1_cp;
            r2_fr    <= r1_ps ? r1_fp : tsau_pkg::FP_W'(w_q);
        end
        if (i_ctl.adv[2]) begin
            r3_conv <= r2_conv;
            r3_t    <= r2_ll + {r2_cross, {tsau_pkg::HALF_W{1'b0}}};
            r3_u    <= (tsau_pkg::CP_W + 1)'(r2_cp) + (tsau_pkg::CP_W + 1)'(r2_fr);
        end
        if (i_ctl.adv[3]) begin
            r4_scalar <= r3_conv ? r3_t + tsau_pkg::SEC_W'(r3_u) : '0;
        end
    end

    assign o_res_scalar = r4_scalar;

    // reciprocal quotient must equal floor(fp / 1000)
    `TSAU_ASSERT_IMP(a_ns_quotient, i_clk, i_ctl.run, i_ctl.vld[0], (32'(w_q) * 32'(tsau_pkg::PS_PER_NS) <= 32'(r1_fp)) && (32'(w_q) * 32'(tsau_pkg::PS_PER_NS) + 32'(tsau_pkg::PS_PER_NS) > 32'(r1_fp)))

endmodule

[hw/rtl/timestamp_arith_unit_top.sv]
// Top level: timestamp add/subtract/convert pipeline with valid/stall control
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------------
//  in      | in        | i_valid / o_stall   | i_action, i_a_*, i_b_* (seconds/coarse/frac)
//  out     | out       | o_valid / i_stall   | o_res_seconds/coarse/frac, o_res_scalar
//
// One transaction per cycle sustained while i_stall is low; results cross the four
// register stages (the widest step is the 32x32 partial product of seconds).
// Reset clears only the stage valid bits.
// A stalled output holds the last stage; earlier stages keep moving into
// empty slots, so bubbles collapse and o_stall rises only when every stage is full.
`include "timestamp_arith_unit_top_defines.svh"
module timestamp_arith_unit_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_action,
    input  logic [tsau_pkg::SEC_W-1:0]     i_a_seconds,
    input  logic [tsau_pkg::COARSE_W-1:0]  i_a_coarse,
    input  logic [tsau_pkg::FRAC_W-1:0]    i_a_frac,
    input  logic [tsau_pkg::SEC_W-1:0]     i_b_seconds,
    input  logic [tsau_pkg::COARSE_W-1:0]  i_b_coarse,
    input  logic [tsau_pkg::FRAC_W-1:0]    i_b_frac,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [tsau_pkg::SEC_W-1:0]     o_res_seconds,
    output logic [tsau_pkg::COARSE_W-1:0]  o_res_coarse,
    output logic [tsau_pkg::FRAC_W-1:0]    o_res_frac,
    output logic [tsau_pkg::SEC_W-1:0]     o_res_scalar
);

    logic [tsau_pkg::NUM_STAGES-1:0] r_vld;
    logic [tsau_pkg::NUM_STAGES-1:0] n_vld;
    logic [tsau_pkg::NUM_STAGES-1:0] w_rdy;
    tsau_pkg::t_pipe_ctl             w_ctl;

    // a stage may load when empty or when the stage after it loads
    always_comb begin
        w_rdy[tsau_pkg::NUM_STAGES-1] = !r_vld[tsau_pkg::NUM_STAGES-1] || !i_stall;
        for (int k = tsau_pkg::NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_rdy[0] ? i_valid : r_vld[0];
        for (int k = 1; k < tsau_pkg::NUM_STAGES; k++) begin
            n_vld[k] = w_rdy[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_comb begin
        w_ctl.run = i_rst_n;
        w_ctl.adv = w_rdy;
        w_ctl.vld = r_vld;
    end

    assign o_stall = !w_rdy[0];
    assign o_valid = r_vld[tsau_pkg::NUM_STAGES-1];

    tsau_tstamp u_tstamp (
        .i_clk         (i_clk),
        .i_ctl         (w_ctl),
        .i_action      (i_action),
        .i_a_seconds   (i_a_seconds),
        .i_a_coarse    (i_a_coarse),
        .i_a_frac      (i_a_frac),
        .i_b_seconds   (i_b_seconds),
        .i_b_coarse    (i_b_coarse),
        .i_b_frac      (i_b_frac),
        .o_res_seconds (o_res_seconds),
        .o_res_coarse  (o_res_coarse),
        .o_res_frac    (o_res_frac)
    );

    tsau_scalar u_scalar (
        .i_clk        (i_clk),
        .i_ctl        (w_ctl),
        .i_action     (i_action),
        .i_a_seconds  (i_a_seconds),
        .i_a_coarse   (i_a_coarse),
        .i_a_frac     (i_a_frac),
        .o_res_scalar (o_res_scalar)
    );

    // an accepted transaction lands in the first stage
    `TSAU_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
    // a held middle stage keeps its transaction
    `TSAU_ASSERT_NEXT(a_mid_holds, i_clk, i_rst_n, r_vld[1] && !w_rdy[2], r_vld[1])
    // without output back-pressure the input never stalls
    `TSAU_ASSERT_IMP(a_no_false_stall, i_clk, i_rst_n, !i_stall, !o_stall)

endmodule
